// ===== rtl/core/sts_pkg.sv =====
// Shared types and constants of the sorted table search engine.
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int LEN_BITS    = ADDR_BITS + 1;
    localparam int WORD_BITS   = 32;
    localparam int TDATA_BITS  = ((ADDR_BITS + WORD_BITS + 7) / 8) * 8;
    localparam int TPAD_BITS   = TDATA_BITS - ADDR_BITS - WORD_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    // Item modes
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_REV    = 2'd1,
        MODE_LINEAR = 2'd2,
        MODE_BINARY = 2'd3
    } mode_t;

    // Classified command passed from front to back
    typedef struct packed {
        mode_t                 mode;
        logic                  in_range;
        logic [ADDR_BITS-1:0]  addr;
        logic [WORD_BITS-1:0]  word;
    } cmd_t;

endpackage

// ===== rtl/core/sts_front.sv =====
// Front end: accepts items, decodes the mode and resolves reverse-read addresses.
module sts_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sts_pkg::TDATA_BITS-1:0] s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,
    input  logic [sts_pkg::LEN_BITS-1:0]  table_len,
    input  logic                          q_full,
    output logic                          q_push,
    output sts_pkg::cmd_t                 q_cmd
);
    import sts_pkg::*;

    logic [ADDR_BITS-1:0] pos;
    logic [LEN_BITS-1:0]  rev_addr;
    mode_t                mode;

    assign pos  = s_axis_tdata[ADDR_BITS-1:0];
    assign mode = mode_t'(s_axis_tuser);

    // Accept whenever the queue has room
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Mirror the position into the live table for reverse reads
    assign rev_addr = table_len - LEN_BITS'(1) - {1'b0, pos};

    // Classify the item
    always_comb
    begin
        q_cmd.mode     = mode;
        q_cmd.word     = s_axis_tdata[ADDR_BITS +: WORD_BITS];
        q_cmd.in_range = 1'b1;
        q_cmd.addr     = pos;
        if (mode == MODE_REV)
        begin
            q_cmd.in_range = ({1'b0, pos} < table_len);
            q_cmd.addr     = rev_addr[ADDR_BITS-1:0];
        end
    end

endmodule

// ===== rtl/core/sts_queue.sv =====
// Short command queue between the front and back ends.
module sts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sts_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output sts_pkg::cmd_t head_cmd
);
    import sts_pkg::*;

    cmd_t                 slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/sts_back.sv =====
// Back end: table memory, search sequencer and output register.
module sts_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sts_pkg::LEN_BITS-1:0]  table_len,
    input  logic                          q_valid,
    input  sts_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_found,
    output logic [sts_pkg::ADDR_BITS-1:0] out_hit,
    output logic [sts_pkg::WORD_BITS-1:0] out_value
);
    import sts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_REV  = 4'b0010,
        ST_LIN  = 4'b0100,
        ST_BIN  = 4'b1000
    } back_state_t;

    // Midpoint of the live interval [lo, hi)
    function automatic logic [ADDR_BITS-1:0] mid_of(input logic [LEN_BITS-1:0] lo,
                                                    input logic [LEN_BITS-1:0] hi);
        logic [LEN_BITS:0] sum;
        sum    = {1'b0, lo} + {1'b0, hi} - (LEN_BITS+1)'(1);
        mid_of = sum[ADDR_BITS:1];
    endfunction

    logic [WORD_BITS-1:0] mem [TABLE_DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    back_state_t          state_reg, state_next;
    logic [ADDR_BITS-1:0] idx_reg, idx_next;
    logic [LEN_BITS-1:0]  lo_reg, lo_next;
    logic [LEN_BITS-1:0]  hi_reg, hi_next;
    logic [WORD_BITS-1:0] key_reg, key_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [ADDR_BITS-1:0] out_hit_reg, out_hit_next;
    logic [WORD_BITS-1:0] out_value_reg, out_value_next;

    logic                 slot_free;
    logic                 out_load;
    logic                 wr_en;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [LEN_BITS-1:0]  nlo;
    logic [LEN_BITS-1:0]  nhi;
    logic [LEN_BITS-1:0]  idx_ext;
    logic                 probe_eq;
    logic                 probe_lt;

    assign slot_free = !out_valid_reg || out_ready;
    assign idx_ext   = {1'b0, idx_reg};
    assign probe_eq  = (rd_data_reg == key_reg);
    assign probe_lt  = ($signed(rd_data_reg) < $signed(key_reg));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        out_load       = 1'b0;
        out_found_next = 1'b0;
        out_hit_next   = '0;
        out_value_next = '0;
        nlo            = lo_reg;
        nhi            = hi_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_cmd.mode == MODE_LOAD || slot_free))
                begin
                    q_pop = 1'b1;
                    case (q_cmd.mode)
                        MODE_LOAD:
                        begin
                            wr_en = 1'b1;
                        end
                        MODE_REV:
                        begin
                            if (q_cmd.in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = q_cmd.addr;
                                state_next = ST_REV;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        MODE_LINEAR:
                        begin
                            key_next = q_cmd.word;
                            if (table_len == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = ST_LIN;
                            end
                        end
                        default:
                        begin
                            key_next = q_cmd.word;
                            lo_next  = '0;
                            hi_next  = table_len;
                            if (table_len == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = mid_of('0, table_len);
                                idx_next   = mid_of('0, table_len);
                                state_next = ST_BIN;
                            end
                        end
                    endcase
                end
            end

            ST_REV:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_value_next = rd_data_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_LIN:
            begin
                if (slot_free)
                begin
                    if (probe_eq)
                    begin
                        out_load       = 1'b1;
                        out_found_next = 1'b1;
                        out_hit_next   = idx_reg;
                        state_next     = ST_IDLE;
                    end
                    else if (idx_ext + LEN_BITS'(1) == table_len)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_BITS'(1);
                        idx_next = idx_reg + ADDR_BITS'(1);
                    end
                end
            end

            ST_BIN:
            begin
                if (slot_free)
                begin
                    if (probe_eq)
                    begin
                        out_load       = 1'b1;
                        out_found_next = 1'b1;
                        out_hit_next   = idx_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // Narrow to the upper or lower half
                        if (probe_lt)
                        begin
                            nlo = idx_ext + LEN_BITS'(1);
                        end
                        else
                        begin
                            nhi = idx_ext;
                        end
                        lo_next = nlo;
                        hi_next = nhi;
                        if (nlo < nhi)
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = mid_of(nlo, nhi);
                            idx_next = mid_of(nlo, nhi);
                        end
                        else
                        begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot: load a result, drop it once taken
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        key_reg <= key_next;
        if (out_load)
        begin
            out_found_reg <= out_found_next;
            out_hit_reg   <= out_hit_next;
            out_value_reg <= out_value_next;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[q_cmd.addr] <= q_cmd.word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_hit   = out_hit_reg;
    assign out_value = out_value_reg;

endmodule

// ===== rtl/core/sorted_table_search_engine_unit.sv =====
// Top level of the sorted table search engine: config register, front, queue, back.
// Throughput: the back end serves one item at a time, with one table read per cycle while
// the result slot is free, so a linear search holds it until the key is found or the scan ends.
// Reset clears control state and table_length; table contents stay undefined until loaded.
module sorted_table_search_engine_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Item input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sts_pkg::TDATA_BITS-1:0] s_axis_tdata,  // position, word, zero pad
    input  logic [1:0]                     s_axis_tuser,  // mode
    // Result output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sts_pkg::TDATA_BITS-1:0] m_axis_tdata,  // hit_index, read_value, zero pad
    output logic [0:0]                     m_axis_tuser,  // found
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [1:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sts_pkg::*;

    logic [LEN_BITS-1:0]  table_length_reg;
    logic [LEN_BITS-1:0]  live_len;
    logic                 cfg_write;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_not_empty;
    cmd_t                 push_cmd;
    cmd_t                 head_cmd;
    logic                 out_found;
    logic [ADDR_BITS-1:0] out_hit;
    logic [WORD_BITS-1:0] out_value;

    // Configuration register: the only register sits at address zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata    = {{(32-LEN_BITS){1'b0}}, table_length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            table_length_reg <= pwdata[LEN_BITS-1:0];
        end
    end

    // Clamp the length to the table depth
    assign live_len = (table_length_reg > LEN_BITS'(TABLE_DEPTH)) ? LEN_BITS'(TABLE_DEPTH)
                                                                 : table_length_reg;

    sts_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .table_len     (live_len),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    sts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    sts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .table_len (live_len),
        .q_valid   (q_not_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_found (out_found),
        .out_hit   (out_hit),
        .out_value (out_value)
    );

    // Pack the result item
    assign m_axis_tdata = {{TPAD_BITS{1'b0}}, out_value, out_hit};
    assign m_axis_tuser = out_found;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the sorted table search engine unit.
`timescale 1ns / 100ps

module tb;

    import sts_pkg::*;

    localparam logic [1:0] ADDR_TABLE_LENGTH = 2'd0;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 220;
    localparam int WIDE_LEN      = 256;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic                        found;
        logic [ADDR_BITS-1:0]        hit_index;
        logic signed [WORD_BITS-1:0] read_value;
    } answer_t;

    // Own model of the table, the length register and the answers still owed
    class lookup_scoreboard;
        logic signed [WORD_BITS-1:0] entries [TABLE_DEPTH];
        logic [LEN_BITS-1:0]         length_reg;
        answer_t                     pending_answers[$];
        int                          errors;

        function new();
            foreach (entries[i]) entries[i] = '0;
            length_reg = '0;
            errors = 0;
        endfunction

        function void set_length(logic [LEN_BITS-1:0] value);
            length_reg = value;
        endfunction

        function int live_len();
            return (length_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_reg);
        endfunction

        function logic signed [WORD_BITS-1:0] entry(int idx);
            return entries[idx];
        endfunction

        // Work out the answer of an accepted item; loads only update the table
        function void predict_answer(mode_t mode, logic [ADDR_BITS-1:0] pos,
                                     logic signed [WORD_BITS-1:0] word);
            answer_t ans;
            int len;
            int lo;
            int hi;
            int mid;
            ans.found = 1'b0;
            ans.hit_index = '0;
            ans.read_value = '0;
            len = live_len();
            if (mode == MODE_LOAD)
            begin
                entries[pos] = word;
                return;
            end
            case (mode)
                MODE_REV:
                begin
                    if (int'(pos) < len)
                        ans.read_value = entries[len - 1 - int'(pos)];
                end
                MODE_LINEAR:
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        if (entries[i] == word)
                        begin
                            ans.found = 1'b1;
                            ans.hit_index = i[ADDR_BITS-1:0];
                            break;
                        end
                    end
                end
                default:
                begin
                    // Midpoint probe, narrow to the upper or lower half
                    lo = 0;
                    hi = len;
                    while (lo < hi)
                    begin
                        mid = (lo + hi - 1) / 2;
                        if (entries[mid] == word)
                        begin
                            ans.found = 1'b1;
                            ans.hit_index = mid[ADDR_BITS-1:0];
                            break;
                        end
                        if (entries[mid] < word)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                end
            endcase
            pending_answers.push_back(ans);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare an accepted result with the oldest owed answer
        task compare_answer(logic found, logic [ADDR_BITS-1:0] hit,
                            logic signed [WORD_BITS-1:0] value);
            answer_t ans;
            if (pending_answers.size() == 0)
            begin
                report("result with no item waiting for it");
                return;
            end
            ans = pending_answers.pop_front();
            if (found !== ans.found)
                report($sformatf("found %b, want %b", found, ans.found));
            if (hit !== ans.hit_index)
                report($sformatf("hit_index %0d, want %0d", hit, ans.hit_index));
            if (value !== ans.read_value)
                report($sformatf("read_value %0d, want %0d", value, ans.read_value));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_BITS-1:0] s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_BITS-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [1:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    lookup_scoreboard sb = new();

    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold;
    int random_items;

    sorted_table_search_engine_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: check accepted items, then pick the next ready level
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.compare_answer(m_axis_tuser[0], m_axis_tdata[ADDR_BITS-1:0],
                                  m_axis_tdata[ADDR_BITS +: WORD_BITS]);
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(mode_t mode, logic [ADDR_BITS-1:0] pos,
                             logic [WORD_BITS-1:0] word);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{TPAD_BITS{1'b0}}, word, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.predict_answer(mode, pos, word);
    endtask

    // Drain every owed answer, let trailing loads retire, then write the length
    task automatic apply_length(logic [LEN_BITS-1:0] len);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_LENGTH;
        pwdata  <= {{(32 - LEN_BITS){1'b0}}, len};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_length(len);
    endtask

    // Key taken from the table, next to an entry, or anywhere
    function automatic logic [WORD_BITS-1:0] pick_key(int len);
        int r;
        int idx;
        r = $urandom_range(99);
        if (len == 0 || r < 15)
            return $urandom;
        idx = $urandom_range(len - 1);
        if (r < 75)
            return sb.entry(idx);
        return (r[0]) ? sb.entry(idx) + 32'sd1 : sb.entry(idx) - 32'sd1;
    endfunction

    // Fill positions 0..len-1, mostly in ascending order
    task automatic load_prefix(int len);
        longint v;
        bit     sorted;
        bit     narrow;
        sorted = ($urandom_range(3) != 0);
        narrow = $urandom_range(1);
        v = narrow ? longint'($urandom_range(16)) - 8
                   : -64'sd2147483648 + longint'($urandom_range(1000000));
        for (int i = 0; i < len; i++)
        begin
            if (sorted)
            begin
                v += narrow ? $urandom_range(3) : $urandom_range(100000000);
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
                send_item(MODE_LOAD, i[ADDR_BITS-1:0], v[31:0]);
            end
            else
                send_item(MODE_LOAD, i[ADDR_BITS-1:0],
                          narrow ? WORD_BITS'($urandom_range(16)) - 8 : $urandom);
            random_items++;
        end
    endtask

    // One random item: mostly lookups, with stray loads as noise
    task automatic run_query(int len);
        int r;
        logic [ADDR_BITS-1:0] pos;
        r = $urandom_range(99);
        if (r < 8)
            send_item(MODE_LOAD, ADDR_BITS'($urandom), $urandom);
        else if (r < 25)
        begin
            pos = (len > 0 && r[0]) ? ADDR_BITS'($urandom_range(len - 1))
                                    : ADDR_BITS'($urandom);
            send_item(MODE_REV, pos, $urandom);
        end
        else if (r < 60)
            send_item(MODE_LINEAR, ADDR_BITS'($urandom), pick_key(len));
        else
            send_item(MODE_BINARY, ADDR_BITS'($urandom), pick_key(len));
    endtask

    initial
    begin
        int len;
        int count;
        longint v;
        logic signed [WORD_BITS-1:0] seed_table [8];

        seed_table = '{WORD_MIN, -32'sd5, 32'sd0, 32'sd0,
                       32'sd3, 32'sd100, 32'sd1000, WORD_MAX};
        src_idle_pct  = 24;
        sink_idle_pct = 65;
        sink_hold     = 0;
        random_items  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_LOAD;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty table: every lookup misses without touching the table
        apply_length('0);
        send_item(MODE_LINEAR, '0, 32'd0);
        send_item(MODE_BINARY, '0, WORD_MAX);
        send_item(MODE_REV, '0, 32'd0);
        send_item(MODE_LOAD, ADDR_BITS'(TABLE_DEPTH - 1), WORD_MIN);
        foreach (seed_table[i])
            send_item(MODE_LOAD, i[ADDR_BITS-1:0], seed_table[i]);

        // Small sorted table with duplicates and both word extremes
        apply_length(11'd8);
        send_item(MODE_REV, '0, 32'd0);
        send_item(MODE_REV, 10'd7, 32'd0);
        send_item(MODE_REV, 10'd8, 32'd0);
        send_item(MODE_REV, 10'd1023, WORD_MAX);
        send_item(MODE_LINEAR, 10'd1023, -32'sd5);
        send_item(MODE_LINEAR, '0, 32'd0);
        send_item(MODE_LINEAR, '0, WORD_MAX);
        send_item(MODE_LINEAR, '0, WORD_MIN);
        send_item(MODE_LINEAR, '0, 32'd7);
        send_item(MODE_BINARY, '0, 32'd3);
        send_item(MODE_BINARY, '0, 32'd1000);
        send_item(MODE_BINARY, '0, WORD_MIN);
        send_item(MODE_BINARY, '0, WORD_MAX);
        send_item(MODE_BINARY, '0, 32'd1);
        send_item(MODE_BINARY, '0, 32'd0);

        // Hold the result side off long enough for the input to back up
        apply_length(11'd4);
        src_idle_pct = 0;
        sink_hold = 300;
        for (int i = 0; i < 40; i++)
            run_query(4);

        // Wide sorted prefix, plus the entries probed on the way down from full depth
        src_idle_pct  = 65;
        sink_idle_pct = 24;
        for (int i = 0; i < WIDE_LEN; i++)
        begin
            v = longint'(i) * 4194304 - 64'sd2147483648 + longint'($urandom_range(4194303));
            send_item(MODE_LOAD, i[ADDR_BITS-1:0], v[31:0]);
        end
        send_item(MODE_LOAD, ADDR_BITS'(TABLE_DEPTH / 2 - 1), WORD_MAX - 32'sd1);
        send_item(MODE_LOAD, ADDR_BITS'(TABLE_DEPTH - 1), WORD_MAX);
        apply_length(LEN_BITS'(WIDE_LEN));
        send_item(MODE_REV, '0, 32'd0);
        send_item(MODE_REV, ADDR_BITS'(WIDE_LEN - 1), 32'd0);
        send_item(MODE_LINEAR, '0, sb.entry(WIDE_LEN - 1));
        send_item(MODE_LINEAR, '0, WORD_MAX);
        send_item(MODE_BINARY, '0, sb.entry(0));
        send_item(MODE_BINARY, '0, sb.entry(WIDE_LEN - 1));
        send_item(MODE_BINARY, '0, sb.entry(117) + 32'sd1);
        for (int i = 0; i < 8; i++)
            run_query(WIDE_LEN);

        // Full depth, then a length beyond it; lookups touch only loaded entries
        apply_length(LEN_BITS'(TABLE_DEPTH));
        send_item(MODE_REV, '0, 32'd0);
        send_item(MODE_REV, 10'd512, 32'd0);
        send_item(MODE_REV, 10'd1023, 32'd0);
        send_item(MODE_LINEAR, '0, sb.entry(0));
        send_item(MODE_BINARY, '0, sb.entry(TABLE_DEPTH / 2 - 1));
        send_item(MODE_BINARY, '0, sb.entry(100));
        send_item(MODE_BINARY, '0, WORD_MIN);
        apply_length(11'd2047);
        send_item(MODE_REV, '0, 32'd0);
        send_item(MODE_LINEAR, '0, sb.entry(0));
        send_item(MODE_BINARY, '0, sb.entry(200));
        send_item(MODE_BINARY, '0, WORD_MIN);

        // Random phases: new length, fresh content, then a burst of items
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 24;
                sink_idle_pct = 65;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 65;
                sink_idle_pct = 24;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case ($urandom_range(9))
                0:       len = 0;
                1:       len = $urandom_range(WIDE_LEN, 64);
                default: len = $urandom_range(24, 1);
            endcase
            apply_length(len[LEN_BITS-1:0]);
            if (len <= 24 && $urandom_range(4) != 0)
                load_prefix(len);
            count = $urandom_range(30, 10);
            for (int i = 0; i < count; i++)
            begin
                run_query(len);
                random_items++;
            end
        end

        // Wait for every owed answer, then a tail for trailing loads
        s_axis_tvalid <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
